// ===== rtl/hpq_pkg.sv =====
// Shared constants, state/command encodings and control structs for the
// max-heap priority queue. No dependencies.
`default_nettype none

package hpq_pkg;

  localparam int CAPACITY    = 128;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  // child index of the deepest slot needs one bit above the address and one for the right child
  localparam int CHILD_W     = ADDR_W + 2;

  localparam logic [VALUE_WIDTH-1:0] NEG_ONE = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_RD,
    ST_POP_LD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_INS_START,
    OP_OVER,
    OP_UNDER,
    OP_POP_RD,
    OP_POP_LD,
    OP_UP_RD,
    OP_UP_CMP,
    OP_DN_RD,
    OP_DN_CMP
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic at_root;
    logic up_move;
    logic last_one;
    logic leaf;
    logic dn_stay;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/hpq_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module hpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/hpq_ctrl.sv =====
// Sequencer for insert (sift up) and pop (sift down) requests.
// Depends on hpq_pkg; drives commands into hpq_dp.
`default_nettype none

module hpq_ctrl
  import hpq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t sts,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    in_stall     = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (sts.is_pop && sts.empty) begin
          cmd.op    = OP_UNDER;
          state_nxt = ST_DONE;
        end else if (sts.is_pop) begin
          state_nxt = ST_POP_RD;
        end else if (sts.full) begin
          cmd.op    = OP_OVER;
          state_nxt = ST_DONE;
        end else begin
          cmd.op    = OP_INS_START;
          state_nxt = ST_UP_RD;
        end
      end
      ST_POP_RD: begin
        cmd.op    = OP_POP_RD;
        state_nxt = ST_POP_LD;
      end
      ST_POP_LD: begin
        cmd.op    = OP_POP_LD;
        state_nxt = sts.last_one ? ST_DONE : ST_DN_RD;
      end
      ST_UP_RD: begin
        cmd.op    = OP_UP_RD;
        state_nxt = sts.at_root ? ST_DONE : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        cmd.op    = OP_UP_CMP;
        state_nxt = sts.up_move ? ST_UP_RD : ST_DONE;
      end
      ST_DN_RD: begin
        cmd.op    = OP_DN_RD;
        state_nxt = sts.leaf ? ST_DONE : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmd.op    = OP_DN_CMP;
        state_nxt = sts.dn_stay ? ST_DONE : ST_DN_RD;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/hpq_dp.sv =====
// Heap datapath: heap RAM, count, moving element, hole position, top copy
// and the result register. Depends on hpq_pkg and hpq_ram.
`default_nettype none

module hpq_dp
  import hpq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output status_t                     sts,
  input  wire logic                   in_action,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [VALUE_WIDTH-1:0]      out_popped_value,
  output logic                        out_underflow,
  output logic                        out_overflow,
  output logic [CNT_W-1:0]            out_element_count,
  output logic [VALUE_WIDTH-1:0]      out_top_value,
  output logic                        out_is_empty,
  output logic                        out_is_full
);

  logic                   pop_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] cur_r;
  logic [ADDR_W-1:0]      pos_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [VALUE_WIDTH-1:0] top_r;
  logic [VALUE_WIDTH-1:0] popped_r;
  logic                   under_r;
  logic                   over_r;
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_popped_r;
  logic                   out_under_r;
  logic                   out_over_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic [VALUE_WIDTH-1:0] out_top_r;
  logic                   out_empty_r;
  logic                   out_full_r;

  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [ADDR_W-1:0]      raddr_a;
  logic [ADDR_W-1:0]      raddr_b;
  logic [VALUE_WIDTH-1:0] rd_a;
  logic [VALUE_WIDTH-1:0] rd_b;

  logic [ADDR_W-1:0]      parent;
  logic [CHILD_W-1:0]     lchild;
  logic [CHILD_W-1:0]     rchild;
  logic [CHILD_W-1:0]     cnt_ext;
  logic [CNT_W-1:0]       cnt_m1;
  logic                   leaf;
  logic                   r_ok;
  logic                   l_gt;
  logic                   r_gt;
  logic                   up_move;
  logic [VALUE_WIDTH-1:0] bigv;

  hpq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  assign parent  = (pos_r - 1'b1) >> 1;
  assign lchild  = {1'b0, pos_r, 1'b1};
  assign rchild  = lchild + 1'b1;
  assign cnt_ext = {{(CHILD_W-CNT_W){1'b0}}, cnt_r};
  assign cnt_m1  = cnt_r - 1'b1;
  assign leaf    = (lchild >= cnt_ext);
  assign r_ok    = (rchild < cnt_ext);

  // sift down: left child wins a tie between children, moves only if strictly greater
  assign l_gt    = ($signed(rd_a) > $signed(cur_r));
  assign bigv    = l_gt ? rd_a : cur_r;
  assign r_gt    = r_ok && ($signed(rd_b) > $signed(bigv));
  assign up_move = ($signed(cur_r) > $signed(rd_a));

  always_comb begin
    we      = 1'b0;
    waddr   = pos_r;
    wdata   = cur_r;
    raddr_a = '0;
    raddr_b = '0;
    unique case (cmd.op)
      OP_POP_RD: raddr_a = cnt_m1[ADDR_W-1:0];
      OP_UP_RD: begin
        if (pos_r == '0) begin
          we = 1'b1;
        end else begin
          raddr_a = parent;
        end
      end
      OP_UP_CMP: begin
        we    = 1'b1;
        wdata = up_move ? rd_a : cur_r;
      end
      OP_DN_RD: begin
        if (leaf) begin
          we = 1'b1;
        end else begin
          raddr_a = lchild[ADDR_W-1:0];
          raddr_b = rchild[ADDR_W-1:0];
        end
      end
      OP_DN_CMP: begin
        we    = 1'b1;
        wdata = r_gt ? rd_b : (l_gt ? rd_a : cur_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        pop_r    <= in_action;
        val_r    <= in_value;
        popped_r <= NEG_ONE;
        under_r  <= 1'b0;
        over_r   <= 1'b0;
      end
      OP_INS_START: begin
        pos_r <= cnt_r[ADDR_W-1:0];
        cur_r <= val_r;
      end
      OP_OVER:   over_r   <= 1'b1;
      OP_UNDER:  under_r  <= 1'b1;
      OP_POP_RD: popped_r <= top_r;
      OP_POP_LD: begin
        cur_r <= rd_a;
        pos_r <= '0;
      end
      OP_UP_CMP: begin
        if (up_move) begin
          pos_r <= parent;
        end
      end
      OP_DN_CMP: begin
        if (r_gt) begin
          pos_r <= rchild[ADDR_W-1:0];
        end else if (l_gt) begin
          pos_r <= lchild[ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
    // shadow copy of the root slot
    if (we && (waddr == '0)) begin
      top_r <= wdata;
    end
    if (cmd.load_out) begin
      out_popped_r <= popped_r;
      out_under_r  <= under_r;
      out_over_r   <= over_r;
      out_cnt_r    <= cnt_r;
      out_top_r    <= (cnt_r == '0) ? NEG_ONE : top_r;
      out_empty_r  <= (cnt_r == '0);
      out_full_r   <= (cnt_r == CNT_W'(CAPACITY));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_INS_START) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.op == OP_POP_LD) begin
        cnt_r <= cnt_m1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.is_pop   = pop_r;
    sts.full     = (cnt_r == CNT_W'(CAPACITY));
    sts.empty    = (cnt_r == '0);
    sts.at_root  = (pos_r == '0);
    sts.up_move  = up_move;
    sts.last_one = (cnt_r == CNT_W'(1));
    sts.leaf     = leaf;
    sts.dn_stay  = !l_gt && !r_gt;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_popped_value  = out_popped_r;
  assign out_underflow     = out_under_r;
  assign out_overflow      = out_over_r;
  assign out_element_count = out_cnt_r;
  assign out_top_value     = out_top_r;
  assign out_is_empty      = out_empty_r;
  assign out_is_full       = out_full_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_sift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_UP_CMP || cmd.op == OP_DN_CMP || cmd.op == OP_DN_RD)
      |-> (CNT_W'(pos_r) < cnt_r))
    else $error("sift position outside stored entries");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_under_r && out_over_r))
    else $error("underflow and overflow on one word");

  a_err_popped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_under_r || out_over_r)) |-> (out_popped_r == NEG_ONE))
    else $error("error word carries a popped value");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_top_r == NEG_ONE && out_cnt_r == '0))
    else $error("empty word carries a top value");

endmodule

`default_nettype wire

// ===== rtl/max_heap_priority_queue.sv =====
// Top level of the binary max-heap priority queue: controller plus datapath.
// Depends on hpq_pkg, hpq_ctrl, hpq_dp (and hpq_ram through hpq_dp).
//
//   channel | direction | handshake             | word
//   in_     | input     | in_valid / in_stall   | action, value
//   out_    | output    | out_valid / out_stall | popped_value, flags, count, top
//
// One request at a time. Insert: the value climbs from the new slot, one parent read
// and one compare per level, until it stops or reaches the root. Pop: the last entry is
// read and moved to the root, then sinks, one children read and one compare per level,
// until it stops or reaches a leaf; taking the last entry ends there. Error requests
// (empty pop, full insert) go from decode straight to the state that loads the output.
// Synchronous active-low reset empties the heap; the RAM needs no clearing pass.
// A finished word waits in the output register while the next request is taken;
// a held word under out_stall keeps the controller waiting before it loads the next.
`default_nettype none

module max_heap_priority_queue
  import hpq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_action,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [VALUE_WIDTH-1:0]      out_popped_value,
  output logic                        out_underflow,
  output logic                        out_overflow,
  output logic [CNT_W-1:0]            out_element_count,
  output logic [VALUE_WIDTH-1:0]      out_top_value,
  output logic                        out_is_empty,
  output logic                        out_is_full
);

  cmd_t    cmd;
  status_t sts;

  hpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hpq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_action),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_popped_value  (out_popped_value),
    .out_underflow     (out_underflow),
    .out_overflow      (out_overflow),
    .out_element_count (out_element_count),
    .out_top_value     (out_top_value),
    .out_is_empty      (out_is_empty),
    .out_is_full       (out_is_full)
  );

endmodule

`default_nettype wire
